FILE: hdl/pacs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pacs_pkg
// Shared types and constants of the principal axis cell split block.
// ----------------------------------------------------------------------------
package pacs_pkg;

  localparam int FRAC_BITS  = 8;
  localparam int MOM_W      = 48;
  localparam int MAC_W      = 26;
  localparam int PROD_W     = 2 * MAC_W;
  localparam int ACC_W      = 101;
  localparam int ROOT_W     = 50;
  localparam int REM_W      = ROOT_W + 3;
  localparam int SQRT_STEPS = 50;
  localparam int CNT_W      = 6;
  localparam int DIFF_W     = 52;
  localparam int FIN_MACS   = 6;
  localparam int CLS_MACS   = 4;
  localparam int CHUNK      = 24;
  localparam int MAG_W      = MOM_W + 1;

  localparam logic signed [MOM_W-1:0] ONE_Q16 = MOM_W'(65536);

  // request modes
  localparam logic [1:0] MODE_ACC = 2'd0;
  localparam logic [1:0] MODE_FIN = 2'd1;
  localparam logic [1:0] MODE_CLS = 2'd2;

  // configuration register indexes
  localparam logic REG_CENTROID_X = 1'b0;
  localparam logic REG_CENTROID_Y = 1'b1;

  // multiply-accumulate shift selections
  typedef enum logic [1:0] {
    SH_0,
    SH_24,
    SH_25,
    SH_48
  } shift_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ACC_MUL,
    ST_ACC_ADD,
    ST_FIN_PREP,
    ST_FIN_MAC,
    ST_FIN_SQRT,
    ST_FIN_DONE,
    ST_CLS_MAC,
    ST_CLS_OUT
  } state_t;

  typedef struct packed {
    logic       load_item;
    logic       acc_mul;
    logic       acc_add;
    logic       fin_prep;
    logic       mac_en;
    logic       mac_cls;
    logic [2:0] mac_idx;
    logic       sqrt_step;
    logic       fin_write;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       xy_zero;
  } status_t;

endpackage

FILE: hdl/pacs_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pacs_in_if / pacs_out_if
// Valid/ready channels for pixel requests and classified pixels.
// ----------------------------------------------------------------------------
interface pacs_in_if #(parameter int COORD_BITS = 10);
  logic                  valid;
  logic                  ready;
  logic [1:0]            mode;
  logic [COORD_BITS-1:0] pixel_x;
  logic [COORD_BITS-1:0] pixel_y;

  modport source (output valid, mode, pixel_x, pixel_y, input ready);
  modport sink (input valid, mode, pixel_x, pixel_y, output ready);
endinterface

interface pacs_out_if #(parameter int COORD_BITS = 10);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] out_x;
  logic [COORD_BITS-1:0] out_y;
  logic                  to_new_cell;

  modport source (output valid, out_x, out_y, to_new_cell, input ready);
  modport sink (input valid, out_x, out_y, to_new_cell, output ready);
endinterface

FILE: hdl/pacs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pacs_ctrl
// Sequencer: accepts requests, steps the datapath, owns output valid.
// ----------------------------------------------------------------------------
module pacs_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  pacs_pkg::status_t  status,
  output pacs_pkg::cmd_t     cmd
);

  pacs_pkg::state_t                state, state_next;
  logic [pacs_pkg::CNT_W-1:0]      cnt, cnt_next;
  logic                            out_valid_next;

  // state, step counter and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pacs_pkg::ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

  // next state and datapath commands
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    in_ready   = 1'b0;
    cmd.mac_idx = cnt[2:0];
    out_valid_next = (out_valid && out_ready) ? 1'b0 : out_valid;
    case (state)
      pacs_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          case (status.mode)
            pacs_pkg::MODE_ACC: state_next = pacs_pkg::ST_ACC_MUL;
            pacs_pkg::MODE_FIN: state_next = pacs_pkg::ST_FIN_PREP;
            pacs_pkg::MODE_CLS: begin
              state_next = pacs_pkg::ST_CLS_MAC;
              cnt_next   = '0;
            end
            default: state_next = pacs_pkg::ST_IDLE;
          endcase
        end
      end
      pacs_pkg::ST_ACC_MUL: begin
        cmd.acc_mul = 1'b1;
        state_next  = pacs_pkg::ST_ACC_ADD;
      end
      pacs_pkg::ST_ACC_ADD: begin
        cmd.acc_add = 1'b1;
        state_next  = pacs_pkg::ST_IDLE;
      end
      pacs_pkg::ST_FIN_PREP: begin
        cmd.fin_prep = 1'b1;
        cnt_next     = '0;
        state_next   = status.xy_zero ? pacs_pkg::ST_FIN_DONE : pacs_pkg::ST_FIN_MAC;
      end
      pacs_pkg::ST_FIN_MAC: begin
        cmd.mac_en = 1'b1;
        if (cnt == pacs_pkg::CNT_W'(pacs_pkg::FIN_MACS - 1)) begin
          cnt_next   = '0;
          state_next = pacs_pkg::ST_FIN_SQRT;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      pacs_pkg::ST_FIN_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (cnt == pacs_pkg::CNT_W'(pacs_pkg::SQRT_STEPS - 1)) begin
          cnt_next   = '0;
          state_next = pacs_pkg::ST_FIN_DONE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      pacs_pkg::ST_FIN_DONE: begin
        cmd.fin_write = 1'b1;
        state_next    = pacs_pkg::ST_IDLE;
      end
      pacs_pkg::ST_CLS_MAC: begin
        cmd.mac_en  = 1'b1;
        cmd.mac_cls = 1'b1;
        if (cnt == pacs_pkg::CNT_W'(pacs_pkg::CLS_MACS - 1)) begin
          cnt_next   = '0;
          state_next = pacs_pkg::ST_CLS_OUT;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      pacs_pkg::ST_CLS_OUT: begin
        // wait for a free output slot
        if (!out_valid || out_ready) begin
          cmd.out_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = pacs_pkg::ST_IDLE;
        end
      end
      default: state_next = pacs_pkg::ST_IDLE;
    endcase
  end

endmodule

FILE: hdl/pacs_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pacs_datapath
// Centroid registers, moment sums, shared multiply-accumulate, square root
// and split axis.
// ----------------------------------------------------------------------------
module pacs_datapath #(
  parameter int COORD_BITS = 10
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic                             cfg_index,
  input  logic [COORD_BITS+pacs_pkg::FRAC_BITS-1:0] cfg_data,
  input  logic [1:0]                       in_mode,
  input  logic [COORD_BITS-1:0]            in_x,
  input  logic [COORD_BITS-1:0]            in_y,
  input  pacs_pkg::cmd_t                   cmd,
  output pacs_pkg::status_t                status,
  output logic [COORD_BITS-1:0]            out_x,
  output logic [COORD_BITS-1:0]            out_y,
  output logic                             to_new_cell
);

  localparam int CW  = COORD_BITS + pacs_pkg::FRAC_BITS;
  localparam int OW  = CW + 1;
  localparam int PW  = 2 * OW;
  localparam int SW  = (PW > pacs_pkg::MOM_W ? PW : pacs_pkg::MOM_W) + 1;
  localparam int MW  = pacs_pkg::MOM_W;
  localparam int AW  = pacs_pkg::ACC_W;
  localparam int XW  = pacs_pkg::MAC_W;
  localparam int DW  = pacs_pkg::DIFF_W;
  localparam int RW  = pacs_pkg::ROOT_W;
  localparam int EW  = pacs_pkg::REM_W;
  localparam int GW  = pacs_pkg::MAG_W;
  localparam int CH  = pacs_pkg::CHUNK;

  localparam logic signed [SW-1:0] SUM_MAX = {{(SW-MW+1){1'b0}}, {(MW-1){1'b1}}};
  localparam logic signed [SW-1:0] SUM_MIN = {{(SW-MW+1){1'b1}}, {(MW-1){1'b0}}};
  localparam logic signed [DW-1:0] AX_MAX  = {{(DW-MW+1){1'b0}}, {(MW-1){1'b1}}};
  localparam logic signed [DW-1:0] AX_MIN  = {{(DW-MW+1){1'b1}}, {(MW-1){1'b0}}};

  logic [CW-1:0]              cen_x, cen_y;
  logic [1:0]                 item_mode;
  logic [COORD_BITS-1:0]      item_x, item_y;
  logic signed [OW-1:0]       ox, oy;
  logic signed [PW-1:0]       pxx, pxy, pyy;
  logic signed [MW-1:0]       mom_xx, mom_xy, mom_yy;
  logic signed [MW-1:0]       axis_dx, axis_dy;
  logic signed [GW-1:0]       a_s;
  logic [GW-1:0]              a_mag, t_mag;
  logic signed [AW-1:0]       acc;
  logic [RW-1:0]              root;
  logic [EW-1:0]              rem;

  // centroid configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      cen_x <= '0;
      cen_y <= '0;
    end else if (cfg_we) begin
      if (cfg_index == pacs_pkg::REG_CENTROID_X) cen_x <= cfg_data;
      else cen_y <= cfg_data;
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_mode <= in_mode;
      item_x    <= in_x;
      item_y    <= in_y;
    end
  end

  // the sequencer branches on the incoming mode while idle
  assign status.mode    = in_mode;
  assign status.xy_zero = (mom_xy == '0);

  // offsets from the centroid, signed q.8
  assign ox = $signed({1'b0, item_x, {pacs_pkg::FRAC_BITS{1'b0}}}) - $signed({1'b0, cen_x});
  assign oy = $signed({1'b0, item_y, {pacs_pkg::FRAC_BITS{1'b0}}}) - $signed({1'b0, cen_y});

  // second moment products
  always_ff @(posedge clk) begin
    if (cmd.acc_mul) begin
      pxx <= ox * ox;
      pxy <= ox * oy;
      pyy <= oy * oy;
    end
  end

  function automatic logic signed [MW-1:0] sat_add(logic signed [MW-1:0] m,
                                                   logic signed [PW-1:0] p);
    logic signed [SW-1:0] s;
    s = SW'(m) + SW'(p);
    if (s > SUM_MAX) return SUM_MAX[MW-1:0];
    if (s < SUM_MIN) return SUM_MIN[MW-1:0];
    return s[MW-1:0];
  endfunction

  // finish values: difference and magnitudes
  always_ff @(posedge clk) begin
    if (cmd.fin_prep) begin
      a_s   <= GW'(mom_xx) - GW'(mom_yy);
      t_mag <= mom_xy[MW-1] ? GW'(-GW'(mom_xy)) << 1 : GW'(mom_xy) << 1;
    end
  end
  assign a_mag = a_s[GW-1] ? GW'(-a_s) : a_s;

  // shared multiply-accumulate operand selection
  logic signed [XW-1:0]     op_a, op_b;
  logic                     op_sub;
  pacs_pkg::shift_t         op_sh;
  logic signed [XW-1:0]     ah, al, th, tl, xh, xl, yh, yl, oxw, oyw;
  logic signed [pacs_pkg::PROD_W-1:0] prod;
  logic signed [AW-1:0]     term, term_sh;

  assign ah  = $signed(XW'(a_mag[GW-1:CH]));
  assign al  = $signed(XW'(a_mag[CH-1:0]));
  assign th  = $signed(XW'(t_mag[GW-1:CH]));
  assign tl  = $signed(XW'(t_mag[CH-1:0]));
  assign xh  = {{(XW-(MW-CH)){axis_dx[MW-1]}}, axis_dx[MW-1:CH]};
  assign xl  = $signed(XW'(axis_dx[CH-1:0]));
  assign yh  = {{(XW-(MW-CH)){axis_dy[MW-1]}}, axis_dy[MW-1:CH]};
  assign yl  = $signed(XW'(axis_dy[CH-1:0]));
  assign oxw = {{(XW-OW){ox[OW-1]}}, ox};
  assign oyw = {{(XW-OW){oy[OW-1]}}, oy};

  always_comb begin
    op_a   = ah;
    op_b   = ah;
    op_sub = 1'b0;
    op_sh  = pacs_pkg::SH_48;
    if (cmd.mac_cls) begin
      case (cmd.mac_idx)
        3'd0: begin op_a = xh; op_b = oyw; op_sh = pacs_pkg::SH_24; end
        3'd1: begin op_a = xl; op_b = oyw; op_sh = pacs_pkg::SH_0; end
        3'd2: begin op_a = oxw; op_b = yh; op_sh = pacs_pkg::SH_24; op_sub = 1'b1; end
        3'd3: begin op_a = oxw; op_b = yl; op_sh = pacs_pkg::SH_0; op_sub = 1'b1; end
        default: ;
      endcase
    end else begin
      case (cmd.mac_idx)
        3'd0: begin op_a = ah; op_b = ah; op_sh = pacs_pkg::SH_48; end
        3'd1: begin op_a = ah; op_b = al; op_sh = pacs_pkg::SH_25; end
        3'd2: begin op_a = al; op_b = al; op_sh = pacs_pkg::SH_0; end
        3'd3: begin op_a = th; op_b = th; op_sh = pacs_pkg::SH_48; end
        3'd4: begin op_a = th; op_b = tl; op_sh = pacs_pkg::SH_25; end
        3'd5: begin op_a = tl; op_b = tl; op_sh = pacs_pkg::SH_0; end
        default: ;
      endcase
    end
  end

  assign prod = op_a * op_b;
  assign term = {{(AW-pacs_pkg::PROD_W){prod[pacs_pkg::PROD_W-1]}}, prod};

  always_comb begin
    case (op_sh)
      pacs_pkg::SH_0:  term_sh = term;
      pacs_pkg::SH_24: term_sh = term <<< 24;
      pacs_pkg::SH_25: term_sh = term <<< 25;
      pacs_pkg::SH_48: term_sh = term <<< 48;
      default:         term_sh = term;
    endcase
  end

  // accumulator, also the radicand shifter during the square root
  logic first_mac;
  assign first_mac = (cmd.mac_idx == 3'd0);

  always_ff @(posedge clk) begin
    if (cmd.mac_en) begin
      if (first_mac) acc <= op_sub ? -term_sh : term_sh;
      else acc <= op_sub ? acc - term_sh : acc + term_sh;
    end else if (cmd.sqrt_step) begin
      acc <= acc <<< 2;
    end
  end

  // bit-by-bit square root, two radicand bits per step
  logic [EW-1:0] rem_sh, trial;
  assign rem_sh = {rem[EW-3:0], acc[AW-2:AW-3]};
  assign trial  = EW'({root, 2'b01});

  always_ff @(posedge clk) begin
    if (cmd.fin_prep) begin
      root <= '0;
      rem  <= '0;
    end else if (cmd.sqrt_step) begin
      if (rem_sh >= trial) begin
        rem  <= rem_sh - trial;
        root <= {root[RW-2:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        root <= {root[RW-2:0], 1'b0};
      end
    end
  end

  // new axis: (a - r) / 2 toward zero, saturated
  logic signed [DW-1:0] diff, half, ax_new;
  assign diff = DW'(a_s) - $signed(DW'(root));
  assign half = (diff + $signed(DW'(diff[DW-1]))) >>> 1;
  assign ax_new = (half > AX_MAX) ? AX_MAX : ((half < AX_MIN) ? AX_MIN : half);

  // moment sums and axis
  always_ff @(posedge clk) begin
    if (rst) begin
      mom_xx  <= '0;
      mom_xy  <= '0;
      mom_yy  <= '0;
      axis_dx <= pacs_pkg::ONE_Q16;
      axis_dy <= '0;
    end else if (cmd.acc_add) begin
      mom_xx <= sat_add(mom_xx, pxx);
      mom_xy <= sat_add(mom_xy, pxy);
      mom_yy <= sat_add(mom_yy, pyy);
    end else if (cmd.fin_write) begin
      if (status.xy_zero) begin
        axis_dx <= pacs_pkg::ONE_Q16;
        axis_dy <= '0;
      end else begin
        axis_dx <= ax_new[MW-1:0];
        axis_dy <= mom_xy;
      end
      mom_xx <= '0;
      mom_xy <= '0;
      mom_yy <= '0;
    end
  end

  // classified pixel register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_x       <= item_x;
      out_y       <= item_y;
      to_new_cell <= !acc[AW-1] && (acc != '0) && (item_mode == pacs_pkg::MODE_CLS);
    end
  end

endmodule

FILE: hdl/principal_axis_cell_split.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// principal_axis_cell_split
// Splits a cell along its principal axis through a configured centroid.
// ----------------------------------------------------------------------------
//  channel  | dir | fields
//  pixels   | in  | mode, pixel_x, pixel_y
//  results  | out | out_x, out_y, to_new_cell
//  cfg      | in  | cfg_we, cfg_index, cfg_data (centroid_x, centroid_y)
//
//  accumulate request: capture, product, saturating add
//  classify request: four steps of the shared 26x26 multiplier
//  finish request: prepare, 6 multiplier steps, the 50-step root, then the axis write;
//    the multiplier steps and the root are skipped when xy is zero
//  reset clears centroid and sums and sets the axis to (1.0, 0) at once; no clearing pass
//  a waiting result holds the output register; the next request is taken
//    meanwhile and only a classify waits for the register to free
module principal_axis_cell_split #(
  parameter int COORD_BITS = 10
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      cfg_we,
  input  logic                                      cfg_index,
  input  logic [COORD_BITS+pacs_pkg::FRAC_BITS-1:0] cfg_data,
  pacs_in_if.sink                                   pixels,
  pacs_out_if.source                                results
);

  pacs_pkg::cmd_t    cmd;
  pacs_pkg::status_t status;

  pacs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pixels.valid),
    .in_ready  (pixels.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .status    (status),
    .cmd       (cmd)
  );

  pacs_datapath #(.COORD_BITS(COORD_BITS)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_mode     (pixels.mode),
    .in_x        (pixels.pixel_x),
    .in_y        (pixels.pixel_y),
    .cmd         (cmd),
    .status      (status),
    .out_x       (results.out_x),
    .out_y       (results.out_y),
    .to_new_cell (results.to_new_cell)
  );

endmodule

FILE: hdl/pacs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pacs_checker
// Port-level checks of the principal axis cell split block.
// ----------------------------------------------------------------------------
module pacs_checker #(
  parameter int COORD_BITS = 10
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic [1:0]            in_mode,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [COORD_BITS-1:0] out_x,
  input logic [COORD_BITS-1:0] out_y,
  input logic                  out_flag
);

  // result held until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // stalled result payload stable
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_x) && $stable(out_y) && $stable(out_flag))
    else $error("result changed while stalled");

  // no result right after reset
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // a finish request keeps the block busy
  a_fin_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_mode == pacs_pkg::MODE_FIN |=> !in_ready)
    else $error("request taken during finish");

endmodule

bind principal_axis_cell_split pacs_checker #(.COORD_BITS(COORD_BITS)) u_pacs_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (pixels.valid),
  .in_ready  (pixels.ready),
  .in_mode   (pixels.mode),
  .out_valid (results.valid),
  .out_ready (results.ready),
  .out_x     (results.out_x),
  .out_y     (results.out_y),
  .out_flag  (results.to_new_cell)
);
